/* sv/owm_pkg.sv */
// Types and constants for the omni-wheel mixer with speed limit.
// Depends on nothing; imported by the top level module.
package owm_pkg;

    // Field widths fixed by the command and set-point formats.
    localparam int IN_W   = 16;
    localparam int MAX_W  = 15;
    localparam int ARM_W  = 13;
    localparam int PROD_W = IN_W + ARM_W;

    // Quotient of the scaling division never exceeds the speed limit.
    localparam int QUO_W              = MAX_W;
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

    localparam int MAX_SPEED_CAP = (2 ** MAX_W) - 1;
    localparam int LEVER_ARM_CAP = (2 ** ARM_W) - 1;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_LEVER_ARM = 1'b1;

    typedef struct packed {
        logic signed [IN_W-1:0] side_speed;
        logic signed [IN_W-1:0] forward_speed;
        logic signed [IN_W-1:0] turn_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [IN_W-1:0] wheel_0;
        logic signed [IN_W-1:0] wheel_1;
        logic signed [IN_W-1:0] wheel_2;
        logic signed [IN_W-1:0] wheel_3;
        logic                   was_scaled;
    } wheel_t;

endpackage

/* sv/omni_wheel_mixer_with_speed_limit_unit.sv */
// Top level of the omni-wheel mixer with speed limit: mixing, limiting and scaling pipeline.
// Depends on owm_pkg for the beat types, field widths and register indexes.
//
//  Channel   | Handshake              | Payload      | Role
//  ----------+------------------------+--------------+----------------------------------
//  cmd       | cmd_valid / cmd_stall  | cmd          | chassis velocity command in
//  wheels    | wheel_valid / wheel_stall | wheels    | four wheel set-points and flag out
//  APB       | psel / penable / pready | paddr/pwdata | speed limit and lever arm registers
//
// One command beat is accepted in every cycle while nothing stalls, and each gives one
// result beat. The pipeline has four arithmetic stages, five divider stages of three
// quotient bits each, and the output register.
// The divider runs four lanes in parallel, one per wheel.
// Each stage is held only while it is full and the stage after it cannot take its beat,
// so bubbles close up and a stall on the result side loses and repeats nothing.
// Reset clears every valid bit and loads the two registers with 4.0 and 0.68.
module omni_wheel_mixer_with_speed_limit_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  owm_pkg::cmd_t   cmd,
    output logic            wheel_valid,
    input  logic            wheel_stall,
    output owm_pkg::wheel_t wheels,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import owm_pkg::*;

    // The rotation term |wz| * arm >> FRAC_BITS grows as FRAC_BITS shrinks, and the
    // wheel sums and divider widths follow from it.
    localparam int RMAG_W = PROD_W - FRAC_BITS;
    localparam int MAG_W  = ((RMAG_W > IN_W + 1) ? RMAG_W : IN_W + 1) + 1;
    localparam int W_W    = MAG_W + 1;
    localparam int ACC_W  = MAG_W + QUO_W;

    localparam int MAX_RST_RAW = 4 * (2 ** FRAC_BITS);
    localparam int ARM_RST_RAW = (68 * (2 ** FRAC_BITS) + 50) / 100;
    localparam logic [MAX_W-1:0] MAX_RST =
        MAX_W'((MAX_RST_RAW > MAX_SPEED_CAP) ? MAX_SPEED_CAP : MAX_RST_RAW);
    localparam logic [ARM_W-1:0] ARM_RST =
        ARM_W'((ARM_RST_RAW > LEVER_ARM_CAP) ? LEVER_ARM_CAP : ARM_RST_RAW);

    // Beat as it passes through the dividend stage and the divider stages. Each
    // accumulator holds the partial remainder above and the dividend/quotient bits below.
    typedef struct packed {
        logic                        scaled;
        logic [3:0]                  neg;
        logic [MAG_W-1:0]            peak;
        logic [3:0][IN_W-1:0]        wheel;
        logic [3:0][ACC_W-1:0]       acc;
    } div_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAX_W-1:0] max_speed_reg;
    logic [ARM_W-1:0] lever_arm_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_RST;
            lever_arm_reg <= ARM_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_SPEED: max_speed_reg <= pwdata[MAX_W-1:0];
                REG_LEVER_ARM: lever_arm_reg <= pwdata[ARM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_SPEED: prdata = 32'(max_speed_reg);
            REG_LEVER_ARM: prdata = 32'(lever_arm_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when the stage after
    // it loads in the same cycle; the chain runs back from the output register.
    // ------------------------------------------------------------------
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic [DIV_STAGES-1:0] vd_reg;
    logic                  rdy1, rdy2, rdy3, rdy4, rdyo;
    logic [DIV_STAGES-1:0] rdyd;

    always_comb
    begin
        rdyo = !vo_reg || !wheel_stall;
        rdyd[DIV_STAGES-1] = !vd_reg[DIV_STAGES-1] || rdyo;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            rdyd[k] = !vd_reg[k] || rdyd[k+1];
        end
        rdy4 = !v4_reg || rdyd[0];
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
    end

    assign cmd_stall = !rdy1;

    // ------------------------------------------------------------------
    // Stage 1: magnitude of the rotation term, |wz| * lever arm.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   wz_neg_reg;
    logic signed [IN_W-1:0] vx_reg, vy_reg;
    logic [IN_W-1:0]        wz_mag;

    always_comb
    begin
        wz_mag    = cmd.turn_rate[IN_W-1] ? IN_W'(-cmd.turn_rate) : cmd.turn_rate;
        prod_next = PROD_W'(wz_mag) * PROD_W'(lever_arm_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            prod_reg   <= prod_next;
            wz_neg_reg <= cmd.turn_rate[IN_W-1];
            vx_reg     <= cmd.side_speed;
            vy_reg     <= cmd.forward_speed;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four wheel sums at full width, so nothing wraps.
    // ------------------------------------------------------------------
    logic signed [W_W-1:0] w_reg  [4];
    logic signed [W_W-1:0] w_next [4];
    logic signed [W_W-1:0] vx_e, vy_e, r_e;
    logic [RMAG_W-1:0]     rmag;

    always_comb
    begin
        rmag = RMAG_W'(prod_reg >> FRAC_BITS);
        vx_e = W_W'(vx_reg);
        vy_e = W_W'(vy_reg);
        r_e  = wz_neg_reg ? -$signed(W_W'(rmag)) : $signed(W_W'(rmag));
        w_next[0] =  vx_e - vy_e - r_e;
        w_next[1] =  vx_e + vy_e - r_e;
        w_next[2] = -vx_e + vy_e - r_e;
        w_next[3] = -vx_e - vy_e - r_e;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            w_reg <= w_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: wheel magnitudes, the largest of them and the limit test.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]      mag_reg  [4];
    logic [MAG_W-1:0]      mag_next [4];
    logic [3:0]            neg3_reg, neg3_next;
    logic [3:0][IN_W-1:0]  wheel3_reg, wheel3_next;
    logic [MAG_W-1:0]      peak3_reg, peak3_next;
    logic                  scaled3_reg, scaled3_next;
    logic [MAG_W-1:0]      p01, p23;
    logic signed [W_W-1:0] w_neg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            w_neg          = -w_reg[i];
            neg3_next[i]   = w_reg[i][W_W-1];
            mag_next[i]    = neg3_next[i] ? w_neg[MAG_W-1:0] : w_reg[i][MAG_W-1:0];
            wheel3_next[i] = w_reg[i][IN_W-1:0];
        end
        p01          = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
        p23          = (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
        peak3_next   = (p01 > p23) ? p01 : p23;
        scaled3_next = peak3_next > MAG_W'(max_speed_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            mag_reg     <= mag_next;
            neg3_reg    <= neg3_next;
            wheel3_reg  <= wheel3_next;
            peak3_reg   <= peak3_next;
            scaled3_reg <= scaled3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: dividends |w| * limit. Since |w| <= peak and the limit is below
    // 2^QUO_W, the top MAG_W bits are already below the peak.
    // ------------------------------------------------------------------
    div_t s4_reg, s4_next;

    always_comb
    begin
        s4_next.scaled = scaled3_reg;
        s4_next.neg    = neg3_reg;
        s4_next.peak   = peak3_reg;
        s4_next.wheel  = wheel3_reg;
        for (int i = 0; i < 4; i++)
        begin
            s4_next.acc[i] = ACC_W'(mag_reg[i]) * ACC_W'(max_speed_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_reg <= s4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to 9: restoring division, three quotient bits per stage in each
    // of the four lanes. The quotient builds up in the low bits of the accumulator.
    // ------------------------------------------------------------------
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input logic [MAG_W-1:0] peak);
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;
        trial = {acc[ACC_W-1:QUO_W], acc[QUO_W-1]};
        diff  = trial - {1'b0, peak};
        ge    = trial >= {1'b0, peak};
        if (ge)
        begin
            return {diff[MAG_W-1:0], acc[QUO_W-2:0], 1'b1};
        end
        return {trial[MAG_W-1:0], acc[QUO_W-2:0], 1'b0};
    endfunction

    div_t div_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        div_t src;
        div_t div_next;

        assign src = (k == 0) ? s4_reg : div_reg[(k == 0) ? 0 : k - 1];

        always_comb
        begin
            div_next = src;
            for (int i = 0; i < 4; i++)
            begin
                for (int s = 0; s < DIV_BITS_PER_STAGE; s++)
                begin
                    div_next.acc[i] = div_step(div_next.acc[i], src.peak);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdyd[k])
            begin
                div_reg[k] <= div_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: output register. Scaled beats take the signed quotient, the others
    // pass the wheel sums, which are then within the limit and fit 16 bits.
    // ------------------------------------------------------------------
    div_t                   last;
    wheel_t                 out_reg, out_next;
    logic signed [IN_W-1:0] res [4];
    logic [IN_W-1:0]        quo;

    assign last = div_reg[DIV_STAGES-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            quo = IN_W'(last.acc[i][QUO_W-1:0]);
            if (last.scaled)
            begin
                res[i] = last.neg[i] ? -$signed(quo) : $signed(quo);
            end
            else
            begin
                res[i] = last.wheel[i];
            end
        end
        out_next.wheel_0    = res[0];
        out_next.wheel_1    = res[1];
        out_next.wheel_2    = res[2];
        out_next.wheel_3    = res[3];
        out_next.was_scaled = last.scaled;
    end

    always_ff @(posedge clk)
    begin
        if (rdyo)
        begin
            out_reg <= out_next;
        end
    end

    assign wheel_valid = vo_reg;
    assign wheels      = out_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vd_reg <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= cmd_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (rdyd[k])
                begin
                    vd_reg[k] <= (k == 0) ? v4_reg : vd_reg[(k == 0) ? 0 : k - 1];
                end
            end
            if (rdyo)
            begin
                vo_reg <= vd_reg[DIV_STAGES-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    function automatic logic within_limit(input logic signed [IN_W-1:0] w,
                                          input logic [MAX_W-1:0]       lim);
        logic signed [IN_W+1:0] we;
        logic signed [IN_W+1:0] le;
        we = (IN_W + 2)'(w);
        le = $signed((IN_W + 2)'(lim));
        return (we <= le) && (we >= -le);
    endfunction

    // Every delivered set-point respects the configured limit.
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid |-> within_limit(wheels.wheel_0, max_speed_reg)
                     && within_limit(wheels.wheel_1, max_speed_reg)
                     && within_limit(wheels.wheel_2, max_speed_reg)
                     && within_limit(wheels.wheel_3, max_speed_reg))
        else $error("wheel set-point beyond the speed limit");

    // An accepted command always lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> v1_reg)
        else $error("accepted command beat lost at the first stage");

    // The first divider stage keeps its beat while it is held.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg[0] && !rdyd[0]) |=> vd_reg[0])
        else $error("divider stage dropped a held beat");

    // A full output register that is stalled keeps the pipeline behind it from overrunning it.
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        (vo_reg && wheel_stall) |-> !rdyo)
        else $error("output register overwritten while stalled");

endmodule

/* tb/omni_wheel_mixer_with_speed_limit_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the omni-wheel mixer with speed limit.
// Depends on owm_pkg and omni_wheel_mixer_with_speed_limit_unit; reads no files.
module omni_wheel_mixer_with_speed_limit_unit_test;
    import owm_pkg::*;

    localparam int FRAC_BITS   = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int GAP_PERCENT = 22;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BEATS = 190;
    // Allow generously for stray beats at the end, beyond the pipeline depth.
    localparam int TAIL_CYCLES = 40;

    // Power-up values of the two registers: 4.0 and 0.68 in Q3.12 and Q1.12.
    localparam int RESET_LIMIT = 16384;
    localparam int RESET_ARM   = 2785;

    // One row of the directed part: the register setting it runs under, the
    // command, and optionally a hand-worked result.
    typedef struct {
        int     limit;
        int     arm;
        cmd_t   command;
        bit     typed;
        wheel_t want;
    } drill_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cmd_valid   = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd         = '0;
    logic        wheel_valid;
    logic        wheel_stall = 1'b0;
    wheel_t      wheels;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Results still owed by the block, oldest first.
    wheel_t wheels_due[$];
    drill_t drill[$];

    // The testbench's own copy of the two registers.
    int cur_limit = RESET_LIMIT;
    int cur_arm   = RESET_ARM;

    bit no_gaps = 1'b0;
    int fails;
    int cycles;
    int beats_sent;
    int results_seen;
    int scaled_seen;
    int settings_used = 1;

    omni_wheel_mixer_with_speed_limit_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .wheel_valid(wheel_valid),
        .wheel_stall(wheel_stall),
        .wheels     (wheels),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run is cut short here if the block hangs or stalls for good.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, wheels_due.size());
            $display("omni_wheel_mixer_with_speed_limit_unit_test failed");
            $finish;
        end
    end

    // Only the first few failures are spelt out; the rest are just counted.
    task automatic note_fail(input string what);
        fails++;
        if (fails <= 10)
            $display("mismatch: %s", what);
    endtask

    // Works out the four wheel set-points and the scaling flag for one command.
    // The raw sums are kept at full integer width, so nothing wraps before
    // limiting; truncation is toward zero in both the lever-arm product and
    // the scaling division.
    function automatic wheel_t mix_wheels(input cmd_t c, input int limit, input int arm);
        int     vx;
        int     vy;
        int     wz;
        int     turn;
        int     mag;
        int     peak;
        longint prod;
        int     w[4];
        wheel_t o;
        vx = c.side_speed;
        vy = c.forward_speed;
        wz = c.turn_rate;
        mag  = (wz < 0) ? -wz : wz;
        prod = (longint'(mag) * arm) >>> FRAC_BITS;
        turn = (wz < 0) ? -int'(prod) : int'(prod);
        w[0] =  vx - vy - turn;
        w[1] =  vx + vy - turn;
        w[2] = -vx + vy - turn;
        w[3] = -vx - vy - turn;
        peak = 0;
        foreach (w[i])
        begin
            mag = (w[i] < 0) ? -w[i] : w[i];
            if (mag > peak)
                peak = mag;
        end
        o.was_scaled = (peak > limit);
        if (o.was_scaled)
        begin
            foreach (w[i])
            begin
                mag  = (w[i] < 0) ? -w[i] : w[i];
                prod = (longint'(mag) * limit) / peak;
                w[i] = (w[i] < 0) ? -int'(prod) : int'(prod);
            end
        end
        o.wheel_0 = 16'(w[0]);
        o.wheel_1 = 16'(w[1]);
        o.wheel_2 = 16'(w[2]);
        o.wheel_3 = 16'(w[3]);
        return o;
    endfunction

    // Result side: every accepted beat is checked against the oldest result
    // owed, and the stall is redrawn each cycle. Values read here are the ones
    // that stood before the edge, since all drivers use nonblocking updates.
    always @(posedge clk)
    begin
        wheel_t want;
        if (rst_n && wheel_valid && !wheel_stall)
        begin
            results_seen++;
            if (wheels.was_scaled)
                scaled_seen++;
            if (wheels_due.size() == 0)
            begin
                note_fail($sformatf("result beat with nothing owed: %0d %0d %0d %0d flag %0b",
                                    wheels.wheel_0, wheels.wheel_1, wheels.wheel_2,
                                    wheels.wheel_3, wheels.was_scaled));
            end
            else
            begin
                want = wheels_due.pop_front();
                if (wheels.wheel_0 !== want.wheel_0 || wheels.wheel_1 !== want.wheel_1 ||
                    wheels.wheel_2 !== want.wheel_2 || wheels.wheel_3 !== want.wheel_3 ||
                    wheels.was_scaled !== want.was_scaled)
                begin
                    note_fail($sformatf({"result %0d: expected %0d %0d %0d %0d flag %0b, ",
                                         "got %0d %0d %0d %0d flag %0b"},
                                        results_seen, want.wheel_0, want.wheel_1,
                                        want.wheel_2, want.wheel_3, want.was_scaled,
                                        wheels.wheel_0, wheels.wheel_1, wheels.wheel_2,
                                        wheels.wheel_3, wheels.was_scaled));
                end
            end
        end
        wheel_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
    end

    // Offers one command beat after a random number of idle cycles and
    // returns at the edge where it is taken. The expected result is queued
    // from the hand-worked value if one is given, else from the predictor.
    // Valid is left high on return so that beats can follow back to back.
    task automatic send_command(input cmd_t c, input bit typed, input wheel_t want);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        wheels_due.push_back(typed ? want : mix_wheels(c, cur_limit, cur_arm));
        beats_sent++;
    endtask

    // Holds the command side idle until every owed result has come back.
    // Each command gives exactly one result, so the pipeline is empty then.
    task automatic settle();
        cmd_valid <= 1'b0;
        while (wheels_due.size() != 0)
            @(posedge clk);
    endtask

    // One APB write followed by a read of the same register. The read must
    // return only the bits that the register holds. The bus is left idle at the
    // end so that back-to-back calls start cleanly.
    task automatic program_reg(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        mask    = (idx == REG_MAX_SPEED) ? MAX_SPEED_CAP : LEVER_ARM_CAP;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== (value & mask))
            note_fail($sformatf("register %0d read back %0h, expected %0h",
                                idx, got, value & mask));
        @(posedge clk);
    endtask

    // Moves to a new register setting once the block has gone quiet. The
    // bits above each register's width are filled with noise, which the
    // block must drop.
    task automatic set_limits(input int limit, input int arm);
        settle();
        program_reg(REG_MAX_SPEED, 32'(limit) | ($urandom << MAX_W));
        program_reg(REG_LEVER_ARM, 32'(arm) | ($urandom << ARM_W));
        cur_limit = limit;
        cur_arm   = arm;
        settings_used++;
    endtask

    task automatic add_row(input int limit, input int arm, input int sx, input int fy,
                           input int tr, input bit typed, input int w0, input int w1,
                           input int w2, input int w3, input bit flag);
        drill_t r;
        r.limit   = limit;
        r.arm     = arm;
        r.command = '{16'(sx), 16'(fy), 16'(tr)};
        r.typed   = typed;
        r.want    = '{16'(w0), 16'(w1), 16'(w2), 16'(w3), flag};
        drill.push_back(r);
    endtask

    // Random speed: in equal shares the whole range, modest values within +/-4096,
    // half the range, and the range's extremes.
    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 8191)) - 4096);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 32767)) - 16384);
        endcase
    endfunction

    initial
    begin
        cmd_t   c;
        wheel_t none;
        int     limit;
        int     arm;
        none = '0;

        // At the power-up setting (limit 4.0, lever arm 0.68).
        // A still command gives still wheels and no scaling.
        add_row(RESET_LIMIT, RESET_ARM, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        // Full-scale sideways and forward commands are squeezed to the limit.
        add_row(RESET_LIMIT, RESET_ARM, 16'h7FFF, 0, 0, 1, 16384, 16384, -16384, -16384, 1);
        add_row(RESET_LIMIT, RESET_ARM, 16'h8000, 0, 0, 1, -16384, -16384, 16384, 16384, 1);
        add_row(RESET_LIMIT, RESET_ARM, 0, 16'h7FFF, 0, 1, -16384, 16384, 16384, -16384, 1);
        add_row(RESET_LIMIT, RESET_ARM, 0, 16'h8000, 0, 0, 0, 0, 0, 0, 0);
        // Pure rotation of 1.0 rad/s turns every wheel by the lever arm.
        add_row(RESET_LIMIT, RESET_ARM, 0, 0, 16'h1000, 1, -2785, -2785, -2785, -2785, 0);
        add_row(RESET_LIMIT, RESET_ARM, 0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        add_row(RESET_LIMIT, RESET_ARM, 0, 0, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_row(RESET_LIMIT, RESET_ARM, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        add_row(RESET_LIMIT, RESET_ARM, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0);
        // A peak exactly at the limit passes; one step above it is scaled.
        add_row(RESET_LIMIT, RESET_ARM, 16'h4000, 0, 0, 1, 16384, 16384, -16384, -16384, 0);
        add_row(RESET_LIMIT, RESET_ARM, 16'h4001, 0, 0, 1, 16384, 16384, -16384, -16384, 1);
        add_row(RESET_LIMIT, RESET_ARM, 16'h0100, 16'h0080, 16'hFF00, 0, 0, 0, 0, 0, 0);
        add_row(RESET_LIMIT, RESET_ARM, 16'h5555, 16'hAAAA, 16'h5555, 0, 0, 0, 0, 0, 0);
        // A zero limit: any motion is scaled to nothing, but a still command
        // or a turn too small to survive the lever arm is not flagged.
        add_row(0, RESET_ARM, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(0, RESET_ARM, 1, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(0, RESET_ARM, 0, 0, 1, 1, 0, 0, 0, 0, 0);
        add_row(0, RESET_ARM, 16'hAAAA, 16'h5555, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        // Widest limit and lever arm: the raw sums reach well past 16 bits.
        add_row(MAX_SPEED_CAP, LEVER_ARM_CAP, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_row(MAX_SPEED_CAP, LEVER_ARM_CAP, 0, 0, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_row(MAX_SPEED_CAP, LEVER_ARM_CAP, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        add_row(MAX_SPEED_CAP, LEVER_ARM_CAP, 16'h0123, 16'hFEDC, 16'h0FFF, 0, 0, 0, 0, 0, 0);
        // Smallest nonzero limit with no lever arm: rotation has no effect.
        add_row(1, 0, 0, 0, 16'h7FFF, 1, 0, 0, 0, 0, 0);
        add_row(1, 0, 3, 1, 16'h8000, 0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: each change of setting waits for the block to empty
        // first, which also serves as the pause with every result returned.
        foreach (drill[i])
        begin
            if (drill[i].limit != cur_limit || drill[i].arm != cur_arm)
                set_limits(drill[i].limit, drill[i].arm);
            send_command(drill[i].command, drill[i].typed, drill[i].want);
        end

        // Random part: several settings, the extremes among them, each with
        // a run of random commands. One phase runs with no idling on either
        // side, so the pipeline is seen full and flowing.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       begin limit = MAX_SPEED_CAP; arm = LEVER_ARM_CAP; end
                1:       begin limit = 1; arm = 0; end
                2:       begin limit = 0; arm = $urandom_range(0, LEVER_ARM_CAP); end
                3:       begin limit = RESET_LIMIT; arm = RESET_ARM; end
                default:
                begin
                    limit = $urandom_range(0, MAX_SPEED_CAP);
                    arm   = $urandom_range(0, LEVER_ARM_CAP);
                end
            endcase
            set_limits(limit, arm);
            no_gaps = (p == 3);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                c.side_speed    = pick_speed();
                c.forward_speed = pick_speed();
                c.turn_rate     = pick_speed();
                send_command(c, 1'b0, none);
            end
            no_gaps = 1'b0;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d commands sent under %0d register settings; %0d results checked, %0d scaled",
                 beats_sent, settings_used, results_seen, scaled_seen);
        $display("%0d failures in %0d cycles", fails, cycles);
        if (fails == 0 && wheels_due.size() == 0)
            $display("omni_wheel_mixer_with_speed_limit_unit_test passed");
        else
            $display("omni_wheel_mixer_with_speed_limit_unit_test failed");
        $finish;
    end

endmodule

/* files.f */
sv/owm_pkg.sv
sv/omni_wheel_mixer_with_speed_limit_unit.sv
tb/omni_wheel_mixer_with_speed_limit_unit_test.sv
